/* rtl/vfcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfcm_pkg: shared constants, types and color table of the false color mapper
// Widths of the fixed point datapath, register codes and the viridis ROM.
// ---------------------------------------------------------------------------
package vfcm_pkg;

   // sample and range format
   localparam int SAMPLE_WIDTH = 32;
   localparam int FRAC_BITS    = 16;
   localparam int CSR_WIDTH    = SAMPLE_WIDTH;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int DIFF_WIDTH   = SAMPLE_WIDTH + 1;
   localparam int SPAN_WIDTH   = SAMPLE_WIDTH;

   // ramp position: segment index plus fraction
   localparam int SEG_BITS     = 4;
   localparam int UBITS        = 16;
   localparam int QUO_BITS     = SEG_BITS + UBITS;
   localparam int REM_WIDTH    = SPAN_WIDTH + SEG_BITS;
   localparam int U_WIDTH      = UBITS + 1;

   // color arithmetic
   localparam int NUM_POINTS   = 11;
   localparam int NUM_CHANNELS = 3;
   localparam int TAB_BITS     = 16;
   localparam int ROW_WIDTH    = NUM_CHANNELS * TAB_BITS;
   localparam int DELTA_WIDTH  = TAB_BITS + 1;
   localparam int C_WIDTH      = TAB_BITS + UBITS + 3;
   localparam int CC_WIDTH     = TAB_BITS + UBITS + 1;
   localparam int BYTE_WIDTH   = 8;
   localparam int SCALE_WIDTH  = CC_WIDTH + BYTE_WIDTH;
   localparam int BYTE_LSB     = TAB_BITS + UBITS;

   // pipeline occupancy: range stages, divider, lookup, multiply, output and skid
   localparam int INFLIGHT_MAX = QUO_BITS + 6;
   localparam int INFLIGHT_WIDTH = $clog2(INFLIGHT_MAX + 1);

   localparam logic [SPAN_WIDTH-1:0]    SPAN_ONE   = SPAN_WIDTH'(1) << FRAC_BITS;
   localparam logic [SEG_BITS-1:0]      LAST_SEG   = SEG_BITS'(NUM_POINTS - 2);
   localparam logic [U_WIDTH-1:0]       U_ONE      = U_WIDTH'(1) << UBITS;
   localparam logic [C_WIDTH-1:0]       C_ONE      = C_WIDTH'(1) << (TAB_BITS + UBITS);
   localparam logic [SCALE_WIDTH-1:0]   ROUND_HALF = SCALE_WIDTH'(1) << (BYTE_LSB - 1);
   localparam logic [SAMPLE_WIDTH-1:0]  RANGE_LOW_RESET  = '0;
   localparam logic [SAMPLE_WIDTH-1:0]  RANGE_HIGH_RESET = SAMPLE_WIDTH'(1) << FRAC_BITS;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RANGE_LOW  = 1'b0,
      CSR_RANGE_HIGH = 1'b1
   } csr_index_type;

   typedef logic [BYTE_WIDTH-1:0] byte_type;

   // viridis control points in Q0.16, packed {blue, green, red}
   function automatic logic [ROW_WIDTH-1:0] viridis_row(input logic [SEG_BITS-1:0] idx);
      logic [ROW_WIDTH-1:0] row;
      case (idx)
         4'd0:    row = {16'd21589, 16'd319,   16'd17498};
         4'd1:    row = {16'd29984, 16'd9236,  16'd18522};
         4'd2:    row = {16'd34733, 16'd17384, 16'd16642};
         4'd3:    row = {16'd36249, 16'd24364, 16'd13550};
         4'd4:    row = {16'd36579, 16'd30876, 16'd10723};
         4'd5:    row = {16'd36081, 16'd37156, 16'd8360};
         4'd6:    row = {16'd33925, 16'd43164, 16'd8827};
         4'd7:    row = {16'd28873, 16'd49070, 16'd17494};
         4'd8:    row = {16'd20853, 16'd53834, 16'd31294};
         4'd9:    row = {16'd9802,  16'd57242, 16'd48588};
         4'd10:   row = {16'd9433,  16'd59386, 16'd65094};
         default: row = '0;
      endcase
      return row;
   endfunction

endpackage
`default_nettype wire

/* rtl/vfcm_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfcm_req_if: sample request channel
// Valid/ready handshake carrying one signed Q16.16 sample.
// ---------------------------------------------------------------------------
interface vfcm_req_if import vfcm_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

/* rtl/vfcm_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfcm_rsp_if: pixel response channel
// Valid/ready handshake carrying one RGB pixel of three bytes.
// ---------------------------------------------------------------------------
interface vfcm_rsp_if import vfcm_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type red;
   byte_type green;
   byte_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

/* rtl/viridis_false_color_mapper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// viridis_false_color_mapper: scalar sample to viridis RGB pixel
// Normalizes a Q16.16 sample against a programmable range and interpolates
// an eleven point viridis ramp into three channel bytes.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req_bus | in        | valid / ready      | sample, signed Q16.16
//  rsp_bus | out       | valid / ready      | red, green, blue bytes
//  csr     | in        | csr_we, no ready   | csr_index, csr_wdata
//
//  Throughput is one request per clock while the skid entry is empty. A request
//  reaches rsp_bus through two range stages, a 20 stage restoring divider (one
//  quotient bit per stage), color lookup, multiply and the output register.
//  The divider chain sets the latency; every stage holds one request.
//  req_bus.ready is a flop: the output register plus one skid entry absorb
//  the request already in flight when rsp_bus stalls, so nothing is dropped.
//  reset is synchronous and clears valid bits, the skid and the range
//  registers (low 0.0, high 1.0); datapath registers are not reset.
//
module viridis_false_color_mapper import vfcm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  csr_index_type          csr_index,
   input  logic [CSR_WIDTH-1:0]   csr_wdata,
   vfcm_req_if.sink               req_bus,
   vfcm_rsp_if.source             rsp_bus
);

   // ------------------------------------------------------------------------
   // Range registers
   // ------------------------------------------------------------------------
   logic [SAMPLE_WIDTH-1:0] range_low_ff;
   logic [SAMPLE_WIDTH-1:0] range_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline enable: advance every stage unless the skid entry is occupied
   // ------------------------------------------------------------------------
   logic pipe_advance;
   logic skid_valid_ff;

   assign pipe_advance  = !skid_valid_ff;
   assign req_bus.ready = pipe_advance;

   // ------------------------------------------------------------------------
   // Stage 1: offset from the low end and span of the range
   // ------------------------------------------------------------------------
   logic signed [DIFF_WIDTH-1:0] s1_diff_in;
   logic signed [DIFF_WIDTH-1:0] s1_hl_diff;
   logic [SPAN_WIDTH-1:0]        s1_span_in;
   logic                         s1_high_gt;
   logic                         s1_valid_ff;
   logic signed [DIFF_WIDTH-1:0] s1_diff_ff;
   logic [SPAN_WIDTH-1:0]        s1_span_ff;

   always_comb begin
      s1_diff_in = $signed({req_bus.sample[SAMPLE_WIDTH-1], req_bus.sample})
                 - $signed({range_low_ff[SAMPLE_WIDTH-1], range_low_ff});
      s1_hl_diff = $signed({range_high_ff[SAMPLE_WIDTH-1], range_high_ff})
                 - $signed({range_low_ff[SAMPLE_WIDTH-1], range_low_ff});
      s1_high_gt = $signed(range_high_ff) > $signed(range_low_ff);
      // empty or inverted range: fall back to a span of 1.0
      s1_span_in = s1_high_gt ? s1_hl_diff[SPAN_WIDTH-1:0] : SPAN_ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         s1_diff_ff <= s1_diff_in;
         s1_span_ff <= s1_span_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: clamp to the ramp and scale the offset by ten
   // ------------------------------------------------------------------------
   logic                  s2_at_low;
   logic                  s2_at_high;
   logic [SPAN_WIDTH-1:0] s2_offset;
   logic [REM_WIDTH-1:0]  s2_scaled;
   logic                  s2_valid_ff;
   logic                  s2_sat_ff;
   logic [REM_WIDTH-1:0]  s2_rem_ff;
   logic [SPAN_WIDTH-1:0] s2_span_ff;

   always_comb begin
      s2_at_low  = s1_diff_ff[DIFF_WIDTH-1] || (s1_diff_ff == '0);
      s2_at_high = s1_diff_ff >= $signed({1'b0, s1_span_ff});
      s2_offset  = s1_diff_ff[SPAN_WIDTH-1:0];
      // offset * 10 as two shifted copies
      s2_scaled  = (REM_WIDTH'(s2_offset) << 3) + (REM_WIDTH'(s2_offset) << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         // below the low end divides zero: segment 0, fraction 0
         s2_sat_ff  <= !s2_at_low && s2_at_high;
         s2_rem_ff  <= (s2_at_low || s2_at_high) ? '0 : s2_scaled;
         s2_span_ff <= s1_span_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Divider: one restoring step per stage, quotient = floor(10*t * 2^16).
   // The partial remainder stays below 16 * span; each step compares it
   // against 8 * span and doubles what is left.
   // ------------------------------------------------------------------------
   logic                  dv_valid_ff [QUO_BITS];
   logic                  dv_sat_ff   [QUO_BITS];
   logic [REM_WIDTH-1:0]  dv_rem_ff   [QUO_BITS];
   logic [QUO_BITS-1:0]   dv_quo_ff   [QUO_BITS];
   logic [SPAN_WIDTH-1:0] dv_span_ff  [QUO_BITS];

   logic                  dv_src_valid [QUO_BITS];
   logic                  dv_src_sat   [QUO_BITS];
   logic [REM_WIDTH-1:0]  dv_src_rem   [QUO_BITS];
   logic [QUO_BITS-1:0]   dv_src_quo   [QUO_BITS];
   logic [SPAN_WIDTH-1:0] dv_src_span  [QUO_BITS];

   logic [REM_WIDTH-1:0]  dv_div8      [QUO_BITS];
   logic                  dv_bit       [QUO_BITS];
   logic [REM_WIDTH-1:0]  dv_left      [QUO_BITS];
   logic [REM_WIDTH-1:0]  dv_rem_in    [QUO_BITS];
   logic [QUO_BITS-1:0]   dv_quo_in    [QUO_BITS];

   always_comb begin
      dv_src_valid[0] = s2_valid_ff;
      dv_src_sat[0]   = s2_sat_ff;
      dv_src_rem[0]   = s2_rem_ff;
      dv_src_quo[0]   = '0;
      dv_src_span[0]  = s2_span_ff;
      for (int j = 1; j < QUO_BITS; j++) begin
         dv_src_valid[j] = dv_valid_ff[j-1];
         dv_src_sat[j]   = dv_sat_ff[j-1];
         dv_src_rem[j]   = dv_rem_ff[j-1];
         dv_src_quo[j]   = dv_quo_ff[j-1];
         dv_src_span[j]  = dv_span_ff[j-1];
      end
   end

   always_comb begin
      for (int j = 0; j < QUO_BITS; j++) begin
         dv_div8[j]   = REM_WIDTH'(dv_src_span[j]) << (SEG_BITS - 1);
         dv_bit[j]    = dv_src_rem[j] >= dv_div8[j];
         dv_left[j]   = dv_bit[j] ? (dv_src_rem[j] - dv_div8[j]) : dv_src_rem[j];
         dv_rem_in[j] = {dv_left[j][REM_WIDTH-2:0], 1'b0};
         dv_quo_in[j] = {dv_src_quo[j][QUO_BITS-2:0], dv_bit[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < QUO_BITS; j++) begin
            dv_valid_ff[j] <= 1'b0;
         end
      end else if (pipe_advance) begin
         for (int j = 0; j < QUO_BITS; j++) begin
            dv_valid_ff[j] <= dv_src_valid[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int j = 0; j < QUO_BITS; j++) begin
            dv_sat_ff[j]  <= dv_src_sat[j];
            dv_rem_ff[j]  <= dv_rem_in[j];
            dv_quo_ff[j]  <= dv_quo_in[j];
            dv_span_ff[j] <= dv_src_span[j];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Lookup: pick the segment end points and the fraction
   // ------------------------------------------------------------------------
   logic [QUO_BITS-1:0]    lk_quo;
   logic [SEG_BITS-1:0]    lk_seg;
   logic [SEG_BITS-1:0]    lk_seg_next;
   logic [U_WIDTH-1:0]     lk_u_in;
   logic [ROW_WIDTH-1:0]   lk_row_a;
   logic [ROW_WIDTH-1:0]   lk_row_b;
   logic [TAB_BITS-1:0]    lk_a_in     [NUM_CHANNELS];
   logic [DELTA_WIDTH-1:0] lk_delta_in [NUM_CHANNELS];
   logic                   lk_valid_ff;
   logic [U_WIDTH-1:0]     lk_u_ff;
   logic [TAB_BITS-1:0]    lk_a_ff     [NUM_CHANNELS];
   logic [DELTA_WIDTH-1:0] lk_delta_ff [NUM_CHANNELS];

   always_comb begin
      lk_quo      = dv_quo_ff[QUO_BITS-1];
      // top of the ramp: last segment at full fraction
      lk_seg      = dv_sat_ff[QUO_BITS-1] ? LAST_SEG : lk_quo[QUO_BITS-1 -: SEG_BITS];
      lk_u_in     = dv_sat_ff[QUO_BITS-1] ? U_ONE : {1'b0, lk_quo[UBITS-1:0]};
      lk_seg_next = lk_seg + SEG_BITS'(1);
      lk_row_a    = viridis_row(lk_seg);
      lk_row_b    = viridis_row(lk_seg_next);
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         lk_a_in[k]     = lk_row_a[k*TAB_BITS +: TAB_BITS];
         lk_delta_in[k] = {1'b0, lk_row_b[k*TAB_BITS +: TAB_BITS]}
                        - {1'b0, lk_row_a[k*TAB_BITS +: TAB_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         lk_valid_ff <= dv_valid_ff[QUO_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         lk_u_ff <= lk_u_in;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            lk_a_ff[k]     <= lk_a_in[k];
            lk_delta_ff[k] <= lk_delta_in[k];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Multiply: c = a * 2^16 + (b - a) * u in Q0.32, one multiplier per lane
   // ------------------------------------------------------------------------
   logic signed [C_WIDTH-1:0] mu_prod [NUM_CHANNELS];
   logic signed [C_WIDTH-1:0] mu_c_in [NUM_CHANNELS];
   logic                      mu_valid_ff;
   logic signed [C_WIDTH-1:0] mu_c_ff [NUM_CHANNELS];

   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         mu_prod[k] = C_WIDTH'($signed(lk_delta_ff[k]))
                    * C_WIDTH'($signed({1'b0, lk_u_ff}));
         mu_c_in[k] = $signed(C_WIDTH'({lk_a_ff[k], UBITS'(0)})) + mu_prod[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         mu_valid_ff <= lk_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            mu_c_ff[k] <= mu_c_in[k];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Byte conversion: clamp to [0, 1.0], then round half up of c * 255
   // ------------------------------------------------------------------------
   logic [CC_WIDTH-1:0]    by_clamped [NUM_CHANNELS];
   logic [SCALE_WIDTH-1:0] by_scaled  [NUM_CHANNELS];
   byte_type               by_byte    [NUM_CHANNELS];

   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (mu_c_ff[k][C_WIDTH-1]) begin
            by_clamped[k] = '0;
         end else if (mu_c_ff[k] > $signed(C_ONE)) begin
            by_clamped[k] = C_ONE[CC_WIDTH-1:0];
         end else begin
            by_clamped[k] = mu_c_ff[k][CC_WIDTH-1:0];
         end
         by_scaled[k] = (SCALE_WIDTH'(by_clamped[k]) << BYTE_WIDTH)
                      - SCALE_WIDTH'(by_clamped[k]) + ROUND_HALF;
         by_byte[k]   = by_scaled[k][BYTE_LSB +: BYTE_WIDTH];
      end
   end

   // ------------------------------------------------------------------------
   // Output register and skid entry
   // ------------------------------------------------------------------------
   logic     out_push;
   logic     out_pop;
   logic     out_valid_ff;
   byte_type out_byte_ff  [NUM_CHANNELS];
   byte_type skid_byte_ff [NUM_CHANNELS];

   assign out_push = pipe_advance && mu_valid_ff;
   assign out_pop  = out_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // pipeline is held; drain the skid into the output once it is taken
         if (out_pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (out_push) begin
         if (out_valid_ff && !out_pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (skid_valid_ff) begin
            if (out_pop) begin
               out_byte_ff[k] <= skid_byte_ff[k];
            end
         end else if (out_push) begin
            if (out_valid_ff && !out_pop) begin
               skid_byte_ff[k] <= by_byte[k];
            end else begin
               out_byte_ff[k] <= by_byte[k];
            end
         end
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.red   = out_byte_ff[0];
   assign rsp_bus.green = out_byte_ff[1];
   assign rsp_bus.blue  = out_byte_ff[2];

endmodule
`default_nettype wire

/* rtl/vfcm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfcm_checker: port level checks of the false color mapper
// Tracks requests in flight and checks stall and ready behavior.
// ---------------------------------------------------------------------------
module vfcm_checker import vfcm_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type rsp_red,
   input byte_type rsp_green,
   input byte_type rsp_blue
);

   logic [INFLIGHT_WIDTH-1:0] inflight_ff;
   logic [INFLIGHT_WIDTH-1:0] inflight_in;

   always_comb begin
      inflight_in = inflight_ff
                  + INFLIGHT_WIDTH'(req_valid && req_ready)
                  - INFLIGHT_WIDTH'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // hold a stalled pixel unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
                                  && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled pixel changed or dropped");

   // drop ready only after the output stalled
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("request ready dropped without an output stall");

   // advance again in the cycle after the sink takes data
   a_ready_back: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |=> req_ready)
      else $error("request ready stayed low while output drained");

   // emit no pixel without an accepted request behind it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("pixel presented with no request in flight");

   // bound the requests held by the pipeline
   a_inflight_max: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= INFLIGHT_WIDTH'(INFLIGHT_MAX))
      else $error("more requests in flight than pipeline stages");

endmodule

bind viridis_false_color_mapper vfcm_checker u_vfcm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_red   (rsp_bus.red),
   .rsp_green (rsp_bus.green),
   .rsp_blue  (rsp_bus.blue)
);
`default_nettype wire

/* test/vfcm_pixel_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfcm_pixel_checker: pixel predictor and scoreboard for the false color mapper
// Tracks range writes, predicts one RGB pixel per accepted sample request and
// compares each returned pixel, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module vfcm_pixel_checker import vfcm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  csr_index_type           csr_index,
   input  logic [CSR_WIDTH-1:0]    csr_wdata,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  byte_type                rsp_red,
   input  byte_type                rsp_green,
   input  byte_type                rsp_blue,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      byte_type red;
      byte_type green;
      byte_type blue;
   } rgb_pixel_type;

   // viridis control points, Q0.16
   localparam int VIRIDIS_RED   [NUM_POINTS] = '{17498, 18522, 16642, 13550, 10723,
                                                 8360, 8827, 17494, 31294, 48588, 65094};
   localparam int VIRIDIS_GREEN [NUM_POINTS] = '{319, 9236, 17384, 24364, 30876,
                                                 37156, 43164, 49070, 53834, 57242, 59386};
   localparam int VIRIDIS_BLUE  [NUM_POINTS] = '{21589, 29984, 34733, 36249, 36579,
                                                 36081, 33925, 28873, 20853, 9802, 9433};

   logic signed [SAMPLE_WIDTH-1:0] range_lo;
   logic signed [SAMPLE_WIDTH-1:0] range_hi;
   rgb_pixel_type                  pixels_due[$];
   rgb_pixel_type                  want;
   int                             mism;

   // blend two table points by a Q0.16 fraction, round half up to a byte
   function automatic byte_type blend_channel(input int a, input int b, input longint frac);
      longint c;
      c = longint'(a) * (longint'(1) << UBITS) + longint'(b - a) * frac;
      if (c < 0) c = 0;
      if (c > (longint'(1) << 32)) c = longint'(1) << 32;
      return byte_type'((c * 255 + (longint'(1) << 31)) >>> 32);
   endfunction

   function automatic rgb_pixel_type map_sample(input longint s, input longint lo,
                                                input longint hi);
      longint        diff, span, n, q, rem, frac;
      int            seg;
      int            k;
      rgb_pixel_type px;
      diff = s - lo;
      span = (hi > lo) ? hi - lo : (longint'(1) << FRAC_BITS);
      if (diff <= 0) begin
         seg  = 0;
         frac = 0;
      end else if (diff >= span) begin
         seg  = NUM_POINTS - 2;
         frac = longint'(1) << UBITS;
      end else begin
         n    = diff * 10;
         q    = n / span;
         rem  = n - q * span;
         frac = 0;
         // restoring division of the remainder, one fraction bit per pass
         for (k = 0; k < UBITS; k++) begin
            rem  = rem * 2;
            frac = frac * 2;
            if (rem >= span) begin
               rem  = rem - span;
               frac = frac + 1;
            end
         end
         if (q > NUM_POINTS - 2) begin
            q    = NUM_POINTS - 2;
            frac = longint'(1) << UBITS;
         end
         seg = int'(q);
      end
      px.red   = blend_channel(VIRIDIS_RED[seg],   VIRIDIS_RED[seg + 1],   frac);
      px.green = blend_channel(VIRIDIS_GREEN[seg], VIRIDIS_GREEN[seg + 1], frac);
      px.blue  = blend_channel(VIRIDIS_BLUE[seg],  VIRIDIS_BLUE[seg + 1],  frac);
      return px;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         range_lo   <= RANGE_LOW_RESET;
         range_hi   <= RANGE_HIGH_RESET;
         pixels_due.delete();
         pending    <= 0;
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RANGE_LOW:  range_lo <= csr_wdata;
               CSR_RANGE_HIGH: range_hi <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pixels_due.push_back(map_sample(longint'($signed(req_sample)),
                                            longint'(range_lo), longint'(range_hi)));
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               $error("pixel returned with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = pixels_due.pop_front();
               mism = 0;
               if (rsp_red !== want.red) begin
                  $error("red: expected %0d, actual %0d", want.red, rsp_red);
                  mism++;
               end
               if (rsp_green !== want.green) begin
                  $error("green: expected %0d, actual %0d", want.green, rsp_green);
                  mism++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue: expected %0d, actual %0d", want.blue, rsp_blue);
                  mism++;
               end
               fail_count <= fail_count + mism;
            end
         end
         pending <= pixels_due.size();
      end
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: regression bench for the viridis false color mapper
// Drives sample requests under a series of range settings with random gaps
// and back-pressure; a side checker predicts and compares every pixel.
// ---------------------------------------------------------------------------
module tb import vfcm_pkg::*; ();

   localparam int PHASES        = 10;
   localparam int PER_PHASE     = 125;
   localparam int SETTLE_CYCLES = 40;      // slack after the last pixel is back
   localparam int CYCLE_LIMIT   = 400000;
   localparam longint INV_LOW   = longint'(3) << 16;

   // range edges, segment boundaries and the extremes of the sample field
   localparam logic [SAMPLE_WIDTH-1:0] DIRECTED [15] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
      32'h0000_FFFF, 32'h0000_0001, 32'h0000_1999, 32'h0000_199A, 32'h0000_8000,
      32'h0000_E666, 32'h0000_E667, 32'h0001_0001, 32'hFFFF_0000, 32'h0000_3333
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;

   vfcm_req_if req_bus ();
   vfcm_rsp_if rsp_bus ();

   int     fail_count;
   int     pending;
   int     cycles = 0;
   int     sent = 0;
   int     settings_used = 0;
   bit     send_gaps;
   bit     sink_stalls;
   longint cur_lo;
   longint cur_hi;
   longint lo_pick;

   viridis_false_color_mapper u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   vfcm_pixel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_sample (req_bus.sample),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_red    (rsp_bus.red),
      .rsp_green  (rsp_bus.green),
      .rsp_blue   (rsp_bus.blue),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   // watchdog: bail out if the pipeline hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // pixel sink: drop ready in random bursts while stalls are enabled
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // saturate to the signed 32 bit sample range
   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647)  return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // pick a sample: mostly inside the ramp, some at its edges and boundaries,
   // some anywhere in the field
   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
      longint          span;
      longint          v;
      longint unsigned rnd;
      span = (cur_hi > cur_lo) ? cur_hi - cur_lo : (longint'(1) << FRAC_BITS);
      rnd  = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         7, 8:    v = ($urandom_range(0, 1) ? cur_lo : cur_lo + span)
                      + longint'(int'($urandom_range(0, 6)) - 3);
         9:       v = cur_lo + span * longint'($urandom_range(0, 10)) / 10
                      + longint'(int'($urandom_range(0, 2)) - 1);
         default: v = cur_lo - span / 8 + longint'(rnd % (span + span / 4 + 1));
      endcase
      v = clip32(v);
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   // present one request and hold it until the mapper takes it
   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value);
      int gap;
      gap = (send_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   // stop sending and wait until every predicted pixel has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both range registers back to back; only called while idle
   task automatic set_range(input longint lo, input longint hi);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_RANGE_LOW;
      csr_wdata <= lo[CSR_WIDTH-1:0];
      @(posedge clock);
      csr_index <= CSR_RANGE_HIGH;
      csr_wdata <= hi[CSR_WIDTH-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
      settings_used++;
   endtask

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_RANGE_LOW;
      csr_wdata      <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      send_gaps   = 1'b0;
      sink_stalls = 1'b0;
      cur_lo      = 0;
      cur_hi      = longint'(1) << FRAC_BITS;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed requests against the reset range of 0.0 to 1.0
      foreach (DIRECTED[i]) send_sample(DIRECTED[i]);
      drain_results();

      // inverted range: span falls back to 1.0 above the low bound
      set_range(INV_LOW, -(longint'(2) << 16));
      send_sample(32'(INV_LOW - 1));
      send_sample(32'(INV_LOW));
      send_sample(32'(INV_LOW + 32768));
      send_sample(32'(INV_LOW + 65535));
      send_sample(32'(INV_LOW + 65536));
      drain_results();

      // random phases, one range setting each
      for (int ph = 0; ph < PHASES; ph++) begin
         lo_pick = longint'($signed($urandom));
         case (ph)
            0: set_range(0, longint'(1) << FRAC_BITS);
            1: set_range(-64'sd2147483648, 64'sd2147483647);
            2: set_range(64'sd2147483647, -64'sd2147483648);
            3: set_range(lo_pick, lo_pick);                  // empty range
            4: set_range(lo_pick, clip32(lo_pick + 1));      // narrowest span
            5: set_range(-(longint'(5) << 16), longint'(3) << 16);
            default: set_range(lo_pick,
                               clip32(lo_pick + longint'($urandom >> $urandom_range(0, 31)) + 1));
         endcase
         for (int i = 0; i < PER_PHASE; i++) begin
            // reshuffle idling every 25 requests; keep the last phase at full rate
            if (i % 25 == 0) begin
               send_gaps   = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
               sink_stalls = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
            end
            send_sample(pick_sample());
            // hold off mid-phase until every outstanding pixel is back
            if (ph == 5 && i == PER_PHASE / 2) drain_results();
         end
         drain_results();
      end

      $display("Mapped %0d samples through %0d range settings (full, empty, inverted, tiny)",
               sent, settings_used);
      $display("Request gaps and pixel back-pressure varied per phase; last phase ran at full rate");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* viridis_false_color_mapper.f */
rtl/vfcm_pkg.sv
rtl/vfcm_req_if.sv
rtl/vfcm_rsp_if.sv
rtl/viridis_false_color_mapper.sv
rtl/vfcm_checker.sv
test/vfcm_pixel_checker.sv
test/tb.sv
